// ===== src/hpfc_pkg.sv =====
package hpfc_pkg;

  // Direction codes carried on func
  localparam logic [1:0] FUNC_S2H = 2'd0;  // single to half
  localparam logic [1:0] FUNC_H2S = 2'd1;  // half to single
  localparam logic [1:0] FUNC_D2H = 2'd2;  // double to half
  localparam logic [1:0] FUNC_H2D = 2'd3;  // half to double

  // Format widths
  localparam int OPND_W = 64;
  localparam int HALF_W = 16;
  localparam int SGL_W  = 32;
  localparam int HMAN_W = 10;
  localparam int DMAN_W = 52;

  // Half encodings
  localparam logic [15:0] HALF_INF = 16'h7C00;

  // Bias differences to half (wide bias minus 15), and the wide biases
  localparam logic signed [11:0] SGL_BDIFF = 12'sd112;
  localparam logic signed [11:0] DBL_BDIFF = 12'sd1008;
  localparam logic signed [11:0] SGL_BIAS  = 12'sd127;
  localparam logic signed [11:0] DBL_BIAS  = 12'sd1023;

  // Fields of a source operand after unpacking to a common wide form
  typedef struct packed {
    logic                sign;
    logic                exp_max;   // source exponent all ones
    logic signed [11:0]  hexp;      // exponent rebiased for half
    logic [DMAN_W-1:0]   frac;      // fraction, left aligned to 52 bits
  } wide_fields_t;

endpackage

// ===== src/hpfc_narrow.sv =====
module hpfc_narrow (
  input  logic                          is_double,
  input  logic [hpfc_pkg::OPND_W-1:0]   operand,
  output logic [hpfc_pkg::HALF_W-1:0]   half
);

  hpfc_pkg::wide_fields_t fld;

  logic [hpfc_pkg::DMAN_W:0]   mant;
  logic [hpfc_pkg::DMAN_W:0]   sub_shift;
  logic [hpfc_pkg::DMAN_W:0]   sub_mask;
  logic [3:0]                  sub_k;
  logic [11:0]                 neg_exp;
  logic [9:0]                  sub_q;
  logic                        sub_inc;
  logic [15:0]                 sub_res;
  logic [9:0]                  nrm_q;
  logic                        nrm_inc;
  logic [15:0]                 nrm_res;
  logic [9:0]                  nan_man;
  logic [14:0]                 mag;

  // Unpack single or double into the common wide form
  always_comb begin
    if (is_double) begin
      fld.sign    = operand[63];
      fld.exp_max = (operand[62:52] == 11'h7FF);
      fld.hexp    = $signed({1'b0, operand[62:52]}) - hpfc_pkg::DBL_BDIFF;
      fld.frac    = operand[51:0];
    end else begin
      fld.sign    = operand[31];
      fld.exp_max = (operand[30:23] == 8'hFF);
      fld.hexp    = $signed({4'b0, operand[30:23]}) - hpfc_pkg::SGL_BDIFF;
      fld.frac    = {operand[22:0], 29'b0};
    end
  end

  assign mant = {1'b1, fld.frac};

  // Subnormal result: shift right by 43 + k, round to nearest even
  assign neg_exp   = 12'd0 - fld.hexp;
  assign sub_k     = neg_exp[3:0];
  assign sub_shift = mant >> sub_k;
  assign sub_mask  = (53'd1 << sub_k) - 53'd1;
  assign sub_q     = sub_shift[52:43];
  assign sub_inc   = sub_shift[42] & ((|sub_shift[41:0]) | (|(mant & sub_mask)) | sub_q[0]);
  assign sub_res   = {6'b0, sub_q} + {15'b0, sub_inc};

  // Normal result: mantissa carry runs into the exponent
  assign nrm_q   = fld.frac[51:42];
  assign nrm_inc = fld.frac[41] & ((|fld.frac[40:0]) | nrm_q[0]);
  assign nrm_res = {1'b0, fld.hexp[4:0], 10'b0} + {6'b0, nrm_q} + {15'b0, nrm_inc};

  // NaN keeps the top mantissa bits, never all zero
  assign nan_man = (nrm_q == 10'd0) ? 10'd1 : nrm_q;

  // Class select
  always_comb begin
    priority if (fld.exp_max) begin
      mag = (fld.frac == '0) ? hpfc_pkg::HALF_INF[14:0] : {5'h1F, nan_man};
    end else if (fld.hexp >= 12'sd31) begin
      mag = hpfc_pkg::HALF_INF[14:0];
    end else if (fld.hexp < -12'sd10) begin
      mag = 15'd0;
    end else if (fld.hexp <= 12'sd0) begin
      mag = sub_res[14:0];
    end else if (nrm_res >= hpfc_pkg::HALF_INF) begin
      mag = hpfc_pkg::HALF_INF[14:0];
    end else begin
      mag = nrm_res[14:0];
    end
  end

  assign half = {fld.sign, mag};

endmodule

// ===== src/hpfc_widen.sv =====
module hpfc_widen (
  input  logic                          is_double,
  input  logic [hpfc_pkg::HALF_W-1:0]   half,
  output logic [hpfc_pkg::OPND_W-1:0]   wide
);

  logic               sign;
  logic [4:0]         hexp;
  logic [9:0]         man;
  logic [3:0]         lz;
  logic [9:0]         sub_frac;
  logic signed [11:0] uexp;
  logic [9:0]         frac;
  logic               is_zero;
  logic               is_spec;
  logic [11:0]        exp_s;
  logic [11:0]        exp_d;
  logic [7:0]         out_exp_s;
  logic [10:0]        out_exp_d;

  assign sign = half[15];
  assign hexp = half[14:10];
  assign man  = half[9:0];

  // Leading-zero count of a subnormal mantissa (highest set bit wins)
  always_comb begin
    lz = 4'd9;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) lz = 4'(9 - i);
    end
  end

  // Drop the leading one of a subnormal
  assign sub_frac = man << (lz + 4'd1);

  assign is_zero = (hexp == 5'd0) && (man == 10'd0);
  assign is_spec = (hexp == 5'h1F);

  // Unbiased exponent and fraction
  always_comb begin
    priority if (is_spec) begin
      uexp = 12'sd0;
      frac = (man == 10'd0) ? 10'd0 : (man | 10'h200);
    end else if (hexp == 5'd0) begin
      uexp = -12'sd15 - $signed({8'b0, lz});
      frac = sub_frac;
    end else begin
      uexp = $signed({7'b0, hexp}) - 12'sd15;
      frac = man;
    end
  end

  assign exp_s = uexp + hpfc_pkg::SGL_BIAS;
  assign exp_d = uexp + hpfc_pkg::DBL_BIAS;

  always_comb begin
    priority if (is_spec) begin
      out_exp_s = 8'hFF;
      out_exp_d = 11'h7FF;
    end else if (is_zero) begin
      out_exp_s = 8'h00;
      out_exp_d = 11'h000;
    end else begin
      out_exp_s = exp_s[7:0];
      out_exp_d = exp_d[10:0];
    end
  end

  // Pack the wide result, zero extended
  assign wide = is_double ? {sign, out_exp_d, frac, 42'b0}
                          : {32'b0, sign, out_exp_s, frac, 13'b0};

endmodule

// ===== src/half_precision_format_converter_unit.sv =====
// Channel   Ports                     Handshake
// -------   -----------------------   -----------------------------------
// input     func, operand             start high and busy low at clk edge
// result    converted                 done high for one cycle, no stall
//
// One item is accepted every cycle; busy is never raised.
// Each item passes the operand register, then the result register,
// with the narrowing or widening logic between them.
// Synchronous active-high rst clears the valid flags of both stages.
// The receiver cannot stall, so results are never held back.
module half_precision_format_converter_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    func,
  input  logic [hpfc_pkg::OPND_W-1:0]   operand,
  output logic                          done,
  output logic [hpfc_pkg::OPND_W-1:0]   converted
);

  logic                          in_valid;
  logic [1:0]                    in_func;
  logic [hpfc_pkg::OPND_W-1:0]   in_opnd;
  logic [hpfc_pkg::HALF_W-1:0]   narrow_half;
  logic [hpfc_pkg::OPND_W-1:0]   widen_word;
  logic [hpfc_pkg::OPND_W-1:0]   converted_next;

  assign busy = 1'b0;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start & ~busy;
    end
    in_func <= func;
    in_opnd <= operand;
  end

  hpfc_narrow u_narrow (
    .is_double (in_func == hpfc_pkg::FUNC_D2H),
    .operand   (in_opnd),
    .half      (narrow_half)
  );

  hpfc_widen u_widen (
    .is_double (in_func == hpfc_pkg::FUNC_H2D),
    .half      (in_opnd[15:0]),
    .wide      (widen_word)
  );

  // Result select
  always_comb begin
    unique case (in_func)
      hpfc_pkg::FUNC_S2H, hpfc_pkg::FUNC_D2H: converted_next = {48'b0, narrow_half};
      default:                                converted_next = widen_word;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    converted <= converted_next;
  end

`ifndef NO_ASSERTIONS
  // Every accepted item comes out after the operand and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(rst, 2)) |-> (done == $past(start, 2)))
    else $error("result strobe does not follow accepted item");

  // Narrowed results are zero above the half field
  a_narrow_zext: assert property (@(posedge clk) disable iff (rst)
    (done && ($past(func, 2) == hpfc_pkg::FUNC_S2H || $past(func, 2) == hpfc_pkg::FUNC_D2H))
    |-> (converted[63:16] == 48'b0))
    else $error("half result not zero extended");

  // Single results are zero above bit 31
  a_single_zext: assert property (@(posedge clk) disable iff (rst)
    (done && $past(func, 2) == hpfc_pkg::FUNC_H2S) |-> (converted[63:32] == 32'b0))
    else $error("single result not zero extended");
`endif

endmodule

// ===== bench/half_precision_format_converter_unit_test.sv =====
`timescale 1ns / 100ps

module half_precision_format_converter_unit_test;

  localparam int RAND_ITEMS  = 1250;
  localparam int STEADY_TAIL = 150;      // last items go back to back
  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_DIRECTED = 25;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [1:0] func;
  logic [hpfc_pkg::OPND_W-1:0] operand;
  logic done;
  logic [hpfc_pkg::OPND_W-1:0] converted;

  // Expected value typed into the directed table travels with the item
  logic typed_valid;
  logic [63:0] typed_value;

  typedef struct packed {
    logic [1:0]  fn;
    logic [63:0] opnd;
    logic        known;
    logic [63:0] want;
  } dir_row_t;

  typedef struct packed {
    logic [1:0]  fn;
    logic [63:0] opnd;
    logic [63:0] value;
  } conv_due_t;

  conv_due_t conversions_due[$];
  int errors = 0;
  int unsigned cycle_count = 0;

  // Extremes, specials and rounding corners; known=0 rows use the predictor
  dir_row_t dir_table [0:NUM_DIRECTED-1] = '{
    {hpfc_pkg::FUNC_S2H, 64'h0000_0000_0000_0000, 1'b1, 64'h0000},
    {hpfc_pkg::FUNC_S2H, 64'h0000_0000_8000_0000, 1'b1, 64'h8000},
    {hpfc_pkg::FUNC_S2H, 64'h0000_0000_3F80_0000, 1'b1, 64'h3C00},
    {hpfc_pkg::FUNC_S2H, 64'hDEAD_BEEF_3F80_0000, 1'b1, 64'h3C00},
    {hpfc_pkg::FUNC_S2H, 64'h0000_0000_477F_E000, 1'b1, 64'h7BFF},
    {hpfc_pkg::FUNC_S2H, 64'h0000_0000_477F_F000, 1'b1, 64'h7C00},
    {hpfc_pkg::FUNC_S2H, 64'h0000_0000_FF80_0000, 1'b1, 64'hFC00},
    {hpfc_pkg::FUNC_S2H, 64'h0000_0000_7FC0_0000, 1'b1, 64'h7E00},
    {hpfc_pkg::FUNC_S2H, 64'h0000_0000_7F80_0001, 1'b1, 64'h7C01},
    {hpfc_pkg::FUNC_S2H, 64'h0000_0000_3380_0000, 1'b1, 64'h0001},
    {hpfc_pkg::FUNC_S2H, 64'h0000_0000_3300_0000, 1'b1, 64'h0000},
    {hpfc_pkg::FUNC_S2H, 64'h0000_0000_387F_F000, 1'b1, 64'h0400},
    {hpfc_pkg::FUNC_S2H, 64'h0000_0000_0000_0001, 1'b1, 64'h0000},
    {hpfc_pkg::FUNC_S2H, 64'h0000_0000_4049_0FDB, 1'b0, 64'h0},
    {hpfc_pkg::FUNC_D2H, 64'h3FF0_0000_0000_0000, 1'b1, 64'h3C00},
    {hpfc_pkg::FUNC_D2H, 64'h7FF0_0000_0000_0001, 1'b1, 64'h7C01},
    {hpfc_pkg::FUNC_D2H, 64'h7FEF_FFFF_FFFF_FFFF, 1'b1, 64'h7C00},
    {hpfc_pkg::FUNC_D2H, 64'h3E70_0000_0000_0000, 1'b1, 64'h0001},
    {hpfc_pkg::FUNC_H2S, 64'h0000_0000_0000_3C00, 1'b1, 64'h3F80_0000},
    {hpfc_pkg::FUNC_H2S, 64'hFFFF_FFFF_FFFF_0001, 1'b1, 64'h3380_0000},
    {hpfc_pkg::FUNC_H2S, 64'h0000_0000_0000_7C01, 1'b1, 64'h7FC0_2000},
    {hpfc_pkg::FUNC_H2S, 64'h0000_0000_0000_03FF, 1'b1, 64'h387F_C000},
    {hpfc_pkg::FUNC_H2D, 64'h0000_0000_0000_3C00, 1'b1, 64'h3FF0_0000_0000_0000},
    {hpfc_pkg::FUNC_H2D, 64'h0000_0000_0000_0001, 1'b1, 64'h3E70_0000_0000_0000},
    {hpfc_pkg::FUNC_H2D, 64'h0000_0000_0000_FFFF, 1'b1, 64'hFFFF_FC00_0000_0000}
  };

  half_precision_format_converter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .func      (func),
    .operand   (operand),
    .done      (done),
    .converted (converted)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shift right by sh, round to nearest, ties to even
  function automatic logic [63:0] rne_shift(logic [63:0] v, int sh);
    logic [63:0] q;
    logic [63:0] below;
    q = v >> sh;
    below = v & ((64'd1 << (sh - 1)) - 64'd1);
    if (v[sh-1] && (below != 64'd0 || q[0])) q = q + 64'd1;
    return q;
  endfunction

  // Wide fields to half; bdiff is the wide bias minus the half bias
  function automatic logic [63:0] narrow_to_half(logic sgn, int ex, logic [63:0] frac,
                                                 int fbits, int emax, int bdiff);
    logic [63:0] s;
    logic [63:0] r;
    logic [63:0] inf;
    s = 64'(sgn) << 15;
    inf = {48'd0, hpfc_pkg::HALF_INF};
    if (ex == emax) begin
      if (frac == 64'd0) return s | inf;
      r = frac >> (fbits - 10);
      if (r == 64'd0) r = 64'd1;
      return s | inf | r;
    end
    if (ex >= bdiff + 31) return s | inf;
    if (ex + 10 < bdiff) return s;
    // half subnormal range; a carry out lands on the smallest normal
    if (ex <= bdiff) return s | rne_shift(frac | (64'd1 << fbits), fbits - 9 + bdiff - ex);
    r = (64'(ex - bdiff) << 10) + rne_shift(frac, fbits - 10);
    if (r >= inf) return s | inf;
    return s | r;
  endfunction

  // Half to a wider format; exact
  function automatic logic [63:0] widen_from_half(logic [15:0] h, int fbits, int ebits);
    int ex;
    int bias;
    int emax;
    int lz;
    logic [9:0] m;
    logic [63:0] s;
    logic [63:0] fmask;
    ex = int'(h[14:10]);
    m = h[9:0];
    bias = (1 << (ebits - 1)) - 1;
    emax = (1 << ebits) - 1;
    fmask = (64'd1 << fbits) - 64'd1;
    s = 64'(h[15]) << (fbits + ebits);
    if (ex == 0 && m == 10'd0) return s;
    if (ex == 31) begin
      if (m == 10'd0) return s | (64'(emax) << fbits);
      return s | (64'(emax) << fbits) | (64'd1 << (fbits - 1)) | (64'(m) << (fbits - 10));
    end
    // subnormal: normalize on the leading one
    if (ex == 0) begin
      lz = 0;
      while (lz < 9 && !m[9-lz]) lz++;
      return s | (64'(bias - 15 - lz) << fbits) | ((64'(m) << (fbits - 9 + lz)) & fmask);
    end
    return s | (64'(ex - 15 + bias) << fbits) | (64'(m) << (fbits - 10));
  endfunction

  function automatic logic [63:0] convert_expected(logic [1:0] fn, logic [63:0] x);
    case (fn)
      hpfc_pkg::FUNC_S2H:
        return narrow_to_half(x[31], int'(x[30:23]), {41'd0, x[22:0]},
                              23, 255, int'(hpfc_pkg::SGL_BDIFF));
      hpfc_pkg::FUNC_H2S:
        return widen_from_half(x[15:0], 23, 8);
      hpfc_pkg::FUNC_D2H:
        return narrow_to_half(x[63], int'(x[62:52]), {12'd0, x[51:0]},
                              hpfc_pkg::DMAN_W, 2047, int'(hpfc_pkg::DBL_BDIFF));
      default:
        return widen_from_half(x[15:0], hpfc_pkg::DMAN_W, 11);
    endcase
  endfunction

  // Wide operand aimed at half range, rounding ties, specials and flush
  function automatic logic [63:0] narrow_operand(logic is_dbl);
    int fbits;
    int ebits;
    int bdiff;
    int emax;
    int ex;
    int sh;
    int pick;
    logic sgn;
    logic [63:0] frac;
    logic [63:0] op;
    fbits = is_dbl ? 52 : 23;
    ebits = is_dbl ? 11 : 8;
    bdiff = is_dbl ? 1008 : 112;
    emax = (1 << ebits) - 1;
    frac = {$urandom, $urandom} & ((64'd1 << fbits) - 64'd1);
    sgn = 1'($urandom_range(0, 1));
    ex = $urandom_range(bdiff + 31, bdiff - 12);
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1: return {$urandom, $urandom};
      6, 7: begin
        // exact tie at the rounding point, or just past it
        sh = (ex > bdiff) ? fbits - 10 : fbits - 9 + bdiff - ex;
        if (sh - 1 < fbits) frac = (frac & ~((64'd1 << sh) - 64'd1)) | (64'd1 << (sh - 1));
        else frac = 64'd0;
        if (pick == 7) frac[0] = 1'b1;
      end
      8: begin
        ex = emax;
        if ($urandom_range(0, 1) == 0) frac = frac & 64'h3FF;
      end
      9: ex = $urandom_range(0, 2);
      default: ;
    endcase
    op = (64'(sgn) << (fbits + ebits)) | (64'(ex) << fbits) | frac;
    if (!is_dbl) op[63:32] = $urandom;
    return op;
  endfunction

  // Half operand with subnormal and NaN/infinity classes; upper bits noise
  function automatic logic [63:0] widen_operand();
    logic [63:0] op;
    int pick;
    op = {$urandom, $urandom};
    pick = $urandom_range(0, 9);
    if (pick == 6 || pick == 7) op[14:10] = 5'd0;
    if (pick >= 8) begin
      op[14:10] = 5'h1F;
      if (pick == 9) op[9:0] = 10'd0;
    end
    return op;
  endfunction

  task automatic put_item(logic [1:0] fn, logic [63:0] opnd, logic known, logic [63:0] want);
    @(negedge clk);
    start <= 1'b1;
    func <= fn;
    operand <= opnd;
    typed_valid <= known;
    typed_value <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(int n);
    @(negedge clk);
    start <= 1'b0;
    typed_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Record accepted items, then check each strobed result in order
  always @(posedge clk) begin
    conv_due_t due;
    if (!rst) begin
      if (start && !busy) begin
        due.fn = func;
        due.opnd = operand;
        due.value = typed_valid ? typed_value : convert_expected(func, operand);
        conversions_due.push_back(due);
      end
      if (done === 1'b1) begin
        if (conversions_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, converted);
        end else begin
          due = conversions_due.pop_front();
          if (converted !== due.value) begin
            errors++;
            $display("%0t: func %0d operand %h: expected %h, actual %h",
                     $time, due.fn, due.opnd, due.value, converted);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [1:0] fn;
    rst = 1'b1;
    start = 1'b0;
    func = hpfc_pkg::FUNC_S2H;
    operand = '0;
    typed_valid = 1'b0;
    typed_value = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed table
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if ($urandom_range(0, 4) == 0) hold_off($urandom_range(1, 11));
      put_item(dir_table[i].fn, dir_table[i].opnd, dir_table[i].known, dir_table[i].want);
    end

    // Random items; gaps stop for the tail
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i < RAND_ITEMS - STEADY_TAIL && $urandom_range(0, 5) == 0)
        hold_off($urandom_range(1, 11));
      fn = 2'($urandom_range(0, 3));
      case (fn)
        hpfc_pkg::FUNC_S2H: put_item(fn, narrow_operand(1'b0), 1'b0, 64'd0);
        hpfc_pkg::FUNC_D2H: put_item(fn, narrow_operand(1'b1), 1'b0, 64'd0);
        default:            put_item(fn, widen_operand(), 1'b0, 64'd0);
      endcase
    end

    @(negedge clk);
    start <= 1'b0;
    typed_valid <= 1'b0;
    while (conversions_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && conversions_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
